// ----- sv/dpw_pkg.sv -----
// ----------------------------------------------------------------------------
// dpw_pkg: shared types and constants of the depth pixel to world point block
// Coordinate type, saturation helper, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dpw_pkg;

  // Signed Q15.16 metres
  typedef logic signed [31:0] coord_t;

  // Register map, one 64-bit slot per register
  typedef enum logic [2:0] {
    REG_PRINCIPAL = 3'd0,
    REG_INV_FOCAL = 3'd1,
    REG_ROT_X     = 3'd2,
    REG_ROT_Y     = 3'd3,
    REG_ROT_Z     = 3'd4,
    REG_SHIFT_X   = 3'd5,
    REG_SHIFT_Y   = 3'd6,
    REG_SHIFT_Z   = 3'd7
  } reg_idx_e;

  localparam int unsigned COLUMN_W = 12;
  localparam int unsigned ROT_W    = 18;
  localparam int unsigned ROW_W    = 3 * ROT_W;
  localparam int unsigned STAGES   = 10;

  localparam logic [31:0]      PP_RESET    = 32'h0FD8_1458;
  localparam logic [63:0]      INV_RESET   = 64'h007E_460B_007E_8473;
  localparam logic [ROW_W-1:0] ROT_X_RESET = 54'h10000;
  localparam logic [ROW_W-1:0] ROT_Y_RESET = 54'h4_0000_0000;
  localparam logic [ROW_W-1:0] ROT_Z_RESET = 54'h10_0000_0000_0000;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

  // Clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input logic signed [63:0] v);
    coord_t r;
    if (v > WIDE_MAX) begin
      r = COORD_MAX;
    end else if (v < WIDE_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/depth_pixel_to_world_point_top.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_top: depth pixel back-projection and pose
// Takes one pixel beat per clock while the output does not stall (column,
// row, raw depth, colour), drops beats whose depth is zero, and for every
// other beat returns the world point in signed Q15.16 metres with the colour
// passed through. The pipeline has ten register stages, built from the
// multiplier pipeline (depth reciprocal, focal scaling, rotation). A stall
// at the output freezes every stage at once, and a dropped pixel leaves an
// empty slot behind. Registers sit on an APB-style port at byte address
// 8*index and must only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_to_world_point_top
  import dpw_pkg::*;
#(
  parameter int unsigned DEPTH_SCALE = 1000,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,

  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // column[11:0], row[23:12], depth_raw[39:24], blue[47:40], green[55:48],
  // red[63:56]
  input  wire logic [63:0]  s_axis_tdata,

  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // world_x[31:0], world_y[63:32], world_z[95:64], point_blue[103:96],
  // point_green[111:104], point_red[119:112]
  output logic [119:0]      m_axis_tdata,

  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  // Only the low COORD_BITS (at most COLUMN_W) of the pixel indices take part
  localparam int unsigned UW = (COORD_BITS < COLUMN_W) ? COORD_BITS : COLUMN_W;
  // floor(2^48 / scale): estimate of the depth quotient, corrected later
  localparam logic [48:0] RECIP = 49'((64'd1 << 48) / 64'(DEPTH_SCALE));
  localparam logic [15:0] SCALE = 16'(DEPTH_SCALE);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0]      pp_q;
  logic [63:0]      inv_q;
  logic [ROW_W-1:0] rot_q [3];
  coord_t           shift_q [3];
  reg_idx_e         reg_sel;

  assign reg_sel = reg_idx_e'(paddr[5:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q       <= PP_RESET;
      inv_q      <= INV_RESET;
      rot_q[0]   <= ROT_X_RESET;
      rot_q[1]   <= ROT_Y_RESET;
      rot_q[2]   <= ROT_Z_RESET;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_PRINCIPAL: pp_q       <= pwdata[31:0];
        REG_INV_FOCAL: inv_q      <= pwdata;
        REG_ROT_X:     rot_q[0]   <= pwdata[ROW_W-1:0];
        REG_ROT_Y:     rot_q[1]   <= pwdata[ROW_W-1:0];
        REG_ROT_Z:     rot_q[2]   <= pwdata[ROW_W-1:0];
        REG_SHIFT_X:   shift_q[0] <= pwdata[31:0];
        REG_SHIFT_Y:   shift_q[1] <= pwdata[31:0];
        REG_SHIFT_Z:   shift_q[2] <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PRINCIPAL: prdata = 64'(pp_q);
      REG_INV_FOCAL: prdata = inv_q;
      REG_ROT_X:     prdata = 64'(rot_q[0]);
      REG_ROT_Y:     prdata = 64'(rot_q[1]);
      REG_ROT_Z:     prdata = 64'(rot_q[2]);
      REG_SHIFT_X:   prdata = 64'(unsigned'(shift_q[0]));
      REG_SHIFT_Y:   prdata = 64'(unsigned'(shift_q[1]));
      REG_SHIFT_Z:   prdata = 64'(unsigned'(shift_q[2]));
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output holds
  // a beat that is not taken.
  // --------------------------------------------------------------------------
  logic              adv;
  logic [STAGES-1:0] v_q;
  logic [15:0]       depth_in;

  assign depth_in      = s_axis_tdata[39:24];
  assign adv           = !v_q[STAGES-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      // Drop unmeasured pixels at the door
      v_q <= {v_q[STAGES-2:0], s_axis_tvalid && (depth_in != 16'd0)};
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1 to 5: depth quotient, pixel offsets, offset * z
  // --------------------------------------------------------------------------
  logic [UW-1:0]      u_in;
  logic [UW-1:0]      v_in;
  logic [15:0]        u_sh;
  logic [15:0]        v_sh;
  logic [23:0]        col_q [STAGES];
  logic [15:0]        d_q [3];
  logic signed [16:0] du_q [4];
  logic signed [16:0] dv_q [4];
  logic [39:0]        drl_q;
  logic [40:0]        drh_q;
  logic [64:0]        dr_full;
  logic [31:0]        qe_q [2];
  logic [47:0]        qs_q;
  logic [47:0]        rem;
  logic [32:0]        zsum;
  logic [30:0]        z_q [4];
  logic signed [47:0] pu_q;
  logic signed [47:0] pv_q;

  assign u_in    = s_axis_tdata[UW-1:0];
  assign v_in    = s_axis_tdata[COLUMN_W +: UW];
  assign u_sh    = 16'({u_in, 4'b0000});
  assign v_sh    = 16'({v_in, 4'b0000});
  assign dr_full = (65'(drh_q) << 24) + 65'(drl_q);
  assign rem     = {d_q[2], 16'd0} - qs_q;
  assign zsum    = {1'b0, qe_q[1]} + 33'(rem >= 48'(SCALE));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: depth times reciprocal in two halves, offsets in 1/16 px
      col_q[0] <= s_axis_tdata[63:40];
      d_q[0]   <= depth_in;
      drl_q    <= 40'(depth_in) * 40'(RECIP[23:0]);
      drh_q    <= 41'(depth_in) * 41'(RECIP[48:24]);
      du_q[0]  <= $signed({1'b0, u_sh}) - $signed({1'b0, pp_q[15:0]});
      dv_q[0]  <= $signed({1'b0, v_sh}) - $signed({1'b0, pp_q[31:16]});
      // Stage 2: quotient estimate, at most one short
      qe_q[0]  <= dr_full[63:32];
      // Stage 3: back-multiply for the remainder
      qe_q[1]  <= qe_q[0];
      qs_q     <= 48'(qe_q[0]) * 48'(SCALE);
      // Stage 4: correct the estimate and clamp z to the positive range
      z_q[0]   <= zsum[32:31] != 2'b00 ? 31'h7FFF_FFFF : zsum[30:0];
      // Stage 5: offsets scaled by z
      pu_q     <= 48'(du_q[3]) * $signed({17'd0, z_q[0]});
      pv_q     <= 48'(dv_q[3]) * $signed({17'd0, z_q[0]});
      // Advance the side lines
      for (int i = 1; i < STAGES; i++) begin
        col_q[i] <= col_q[i-1];
      end
      for (int i = 1; i < 3; i++) begin
        d_q[i] <= d_q[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        du_q[i] <= du_q[i-1];
        dv_q[i] <= dv_q[i-1];
        z_q[i]  <= z_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6 and 7: camera x and y
  // --------------------------------------------------------------------------
  coord_t cam_x;
  coord_t cam_y;
  coord_t cam_z;

  dpw_cam_axis u_cam_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .prod_i  (pu_q),
    .inv_i   (inv_q[31:0]),
    .coord_o (cam_x)
  );

  dpw_cam_axis u_cam_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .prod_i  (pv_q),
    .inv_i   (inv_q[63:32]),
    .coord_o (cam_y)
  );

  // z has waited in its line until x and y are ready
  assign cam_z = $signed({1'b0, z_q[3]});

  // --------------------------------------------------------------------------
  // Stages 8 to 10: rotation and translation, last stage is the output beat
  // --------------------------------------------------------------------------
  coord_t world [3];

  for (genvar a = 0; a < 3; a++) begin : g_world
    dpw_world_axis u_world (
      .clk_i   (clk_i),
      .en_i    (adv),
      .row_i   (rot_q[a]),
      .x_i     (cam_x),
      .y_i     (cam_y),
      .z_i     (cam_z),
      .shift_i (shift_q[a]),
      .world_o (world[a])
    );
  end

  assign m_axis_tdata = {col_q[STAGES-1], world[2], world[1], world[0]};

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // An unmeasured pixel never occupies the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && depth_in == 16'd0) |=> !v_q[0])
    else $error("zero-depth beat entered the pipeline");

  // A held output beat blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // A beat in the last inner stage reaches the output on advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[STAGES-2] && adv) |=> m_axis_tvalid)
    else $error("beat lost before the output stage");

endmodule

`default_nettype wire

// ----- sv/dpw_cam_axis.sv -----
// ----------------------------------------------------------------------------
// dpw_cam_axis: scale one camera axis by a reciprocal focal length
// Two stages: split partial products, then sum, floor shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module dpw_cam_axis
  import dpw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [47:0] prod_i,   // offset * z, 1/16 px * Q15.16
  input  wire logic [31:0]        inv_i,    // reciprocal focal, Q0.32
  output coord_t                  coord_o
);

  logic signed [23:0] prod_hi;
  logic [23:0]        prod_lo;
  logic signed [56:0] hi_q;
  logic [55:0]        lo_q;
  logic signed [80:0] full;
  coord_t             coord_q;

  assign prod_hi = prod_i[47:24];
  assign prod_lo = prod_i[23:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q <= 57'(prod_hi) * $signed({25'd0, inv_i});
      lo_q <= 56'(prod_lo) * 56'(inv_i);
    end
  end

  // Arithmetic shift gives the floor for negative offsets too
  assign full = (81'(hi_q) <<< 24) + $signed({25'd0, lo_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coord_q <= sat_coord(64'(full >>> 36));
    end
  end

  assign coord_o = coord_q;

endmodule

`default_nettype wire

// ----- sv/dpw_world_axis.sv -----
// ----------------------------------------------------------------------------
// dpw_world_axis: one row of the rigid transform
// Three stages: row products, sum, floor shift plus translation with clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module dpw_world_axis
  import dpw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [ROW_W-1:0] row_i,    // three Q1.16 terms, element 0 lowest
  input  coord_t                x_i,
  input  coord_t                y_i,
  input  coord_t                z_i,
  input  coord_t                shift_i,
  output coord_t                world_o
);

  logic signed [ROT_W-1:0] term [3];
  logic signed [49:0]      prod_q [3];
  logic signed [51:0]      acc_q;
  coord_t                  world_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k] = row_i[ROT_W*k +: ROT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= 50'(term[0]) * 50'(x_i);
      prod_q[1] <= 50'(term[1]) * 50'(y_i);
      prod_q[2] <= 50'(term[2]) * 50'(z_i);
      acc_q     <= 52'(prod_q[0]) + 52'(prod_q[1]) + 52'(prod_q[2]);
      world_q   <= sat_coord(64'(acc_q >>> 16) + 64'(shift_i));
    end
  end

  assign world_o = world_q;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for depth_pixel_to_world_point_top
// Streams pixel beats into the block under several pose and camera settings,
// predicts every world point in wide fixed-point arithmetic and checks each
// output beat field by field, in order, against the predicted points.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import dpw_pkg::*;

  localparam int unsigned DEPTH_SCALE    = 1000;
  localparam int unsigned COORD_BITS     = 12;
  // Pipeline is ten stages deep; leave a generous margin for idle checks
  localparam int          DRAIN_CYCLES   = 24;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_BATCH   = 130;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  // Highest field first, so world_x lands in the lowest bits of the beat
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    coord_t      world_z;
    coord_t      world_y;
    coord_t      world_x;
  } world_point_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [63:0]   s_axis_tdata  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [119:0]  m_axis_tdata;
  logic          psel          = 1'b0;
  logic          penable       = 1'b0;
  logic          pwrite        = 1'b0;
  logic [5:0]    paddr         = '0;
  logic [63:0]   pwdata        = '0;
  logic [63:0]   prdata;
  logic          pready;

  always #2 clk_i = ~clk_i;

  depth_pixel_to_world_point_top #(
    .DEPTH_SCALE (DEPTH_SCALE),
    .COORD_BITS  (COORD_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the camera and pose registers
  // --------------------------------------------------------------------------
  logic [31:0]   pp_shadow;
  logic [63:0]   inv_shadow;
  logic [53:0]   rot_shadow [3];
  logic [31:0]   shift_shadow [3];

  pixel_t        pending_pixels [$];
  world_point_t  expected_points [$];
  int            err_cnt  = 0;
  bit            tx_idle  = 1'b0;
  bit            rx_idle  = 1'b0;

  // Append to the tail of the pending and expected queues
  function automatic void append_pixel(input pixel_t px);
    pending_pixels.insert(pending_pixels.size(), px);
  endfunction

  function automatic void append_point(input world_point_t pt);
    expected_points.insert(expected_points.size(), pt);
  endfunction

  // Clamp a wide value to signed Q15.16
  function automatic coord_t clamp_q16(input logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Pull one signed Q1.16 rotation term out of a row
  function automatic logic signed [127:0] rot_term(input logic [53:0] r, input int k);
    logic signed [17:0] t;
    t = r[18*k +: 18];
    return t;
  endfunction

  // floor(diff * z * inv / 2^36), saturated; diff in 1/16 px, inv in Q0.32
  function automatic coord_t cam_axis(input logic signed [127:0] diff,
                                      input logic signed [127:0] z,
                                      input logic [31:0] inv);
    logic signed [127:0] inv_w;
    logic signed [127:0] prod;
    inv_w = $signed({96'd0, inv});
    prod  = diff * z * inv_w;
    return clamp_q16(prod >>> 36);
  endfunction

  function automatic coord_t world_axis(input int axis, input coord_t cx, input coord_t cy,
                                        input coord_t cz);
    logic signed [127:0] acc;
    logic signed [127:0] xw, yw, zw, sw;
    logic signed [31:0]  sh;
    xw  = cx;
    yw  = cy;
    zw  = cz;
    sh  = shift_shadow[axis];
    sw  = sh;
    acc = rot_term(rot_shadow[axis], 0) * xw + rot_term(rot_shadow[axis], 1) * yw
        + rot_term(rot_shadow[axis], 2) * zw;
    return clamp_q16((acc >>> 16) + sw);
  endfunction

  // Back-project one pixel and apply the pose; zero depth yields nothing
  function automatic bit project_pixel(input pixel_t px, output world_point_t pt);
    logic [63:0]         zq;
    logic signed [127:0] z_w, du, dv;
    coord_t              cx, cy, cz;
    pt = '0;
    if (px.depth == 16'd0) begin
      return 1'b0;
    end
    zq = {32'd0, px.depth, 16'd0} / 64'(DEPTH_SCALE);
    if (zq > 64'h7FFF_FFFF) begin
      zq = 64'h7FFF_FFFF;
    end
    z_w = $signed({64'd0, zq});
    cz  = zq[31:0];
    du  = $signed({112'd0, px.column, 4'd0}) - $signed({112'd0, pp_shadow[15:0]});
    dv  = $signed({112'd0, px.row, 4'd0}) - $signed({112'd0, pp_shadow[31:16]});
    cx  = cam_axis(du, z_w, inv_shadow[31:0]);
    cy  = cam_axis(dv, z_w, inv_shadow[63:32]);
    pt.world_x = world_axis(0, cx, cy, cz);
    pt.world_y = world_axis(1, cx, cy, cz);
    pt.world_z = world_axis(2, cx, cy, cz);
    pt.blue    = px.blue;
    pt.green   = px.green;
    pt.red     = px.red;
    return 1'b1;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Pixel driver: hold the beat until taken, then advance to the next one
  // --------------------------------------------------------------------------
  pixel_t        tx_pixel;
  int            tx_gap = 0;

  always @(posedge clk_i) begin
    world_point_t pt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (project_pixel(tx_pixel, pt)) begin
          append_point(pt);
        end
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          tx_pixel = pending_pixels.pop_front();
          s_axis_tdata  <= {tx_pixel.red, tx_pixel.green, tx_pixel.blue, tx_pixel.depth,
                            tx_pixel.row, tx_pixel.column};
          s_axis_tvalid <= 1'b1;
          tx_gap = tx_idle ? pick_gap() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Point monitor: check each taken beat against the oldest prediction
  // --------------------------------------------------------------------------
  int            rx_stall = 0;

  always @(posedge clk_i) begin
    world_point_t exp_pt;
    world_point_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_points.size() == 0) begin
          $error("unexpected point beat: %h", m_axis_tdata);
          err_cnt++;
        end else begin
          exp_pt = expected_points.pop_front();
          if (got.world_x !== exp_pt.world_x) begin
            $error("world_x: expected %0d, got %0d", exp_pt.world_x, got.world_x);
            err_cnt++;
          end
          if (got.world_y !== exp_pt.world_y) begin
            $error("world_y: expected %0d, got %0d", exp_pt.world_y, got.world_y);
            err_cnt++;
          end
          if (got.world_z !== exp_pt.world_z) begin
            $error("world_z: expected %0d, got %0d", exp_pt.world_z, got.world_z);
            err_cnt++;
          end
          if (got.blue !== exp_pt.blue) begin
            $error("point_blue: expected %0d, got %0d", exp_pt.blue, got.blue);
            err_cnt++;
          end
          if (got.green !== exp_pt.green) begin
            $error("point_green: expected %0d, got %0d", exp_pt.green, got.green);
            err_cnt++;
          end
          if (got.red !== exp_pt.red) begin
            $error("point_red: expected %0d, got %0d", exp_pt.red, got.red);
            err_cnt++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_stall = rx_idle ? pick_gap() : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long
  // --------------------------------------------------------------------------
  int            quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_pixel(input logic [11:0] col, input logic [11:0] rw,
                             input logic [15:0] dep, input logic [7:0] b,
                             input logic [7:0] g, input logic [7:0] r);
    pixel_t px;
    px.column = col;
    px.row    = rw;
    px.depth  = dep;
    px.blue   = b;
    px.green  = g;
    px.red    = r;
    append_pixel(px);
  endtask

  // Random pixels: edges of the image now and then, a spread of depths
  task automatic queue_random(input int n);
    pixel_t px;
    int     sel;
    for (int i = 0; i < n; i++) begin
      px.column = ($urandom_range(0, 9) == 0) ? {12{1'($urandom_range(0, 1))}}
                                               : 12'($urandom);
      px.row    = ($urandom_range(0, 9) == 0) ? {12{1'($urandom_range(0, 1))}}
                                               : 12'($urandom);
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        px.depth = 16'd0;
      end else if (sel < 6) begin
        px.depth = 16'($urandom_range(1, 3000));
      end else if (sel == 6) begin
        px.depth = 16'hFFFF;
      end else begin
        px.depth = 16'($urandom);
      end
      px.blue   = 8'($urandom);
      px.green  = 8'($urandom);
      px.red    = 8'($urandom);
      append_pixel(px);
    end
  endtask

  // Wait until every pixel is taken and every point has come back, then
  // let the pipeline empty of dropped beats too
  task automatic drain_pipeline();
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_points.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    logic [63:0] width_mask;
    case (idx)
      REG_PRINCIPAL: begin
        pp_shadow  = val[31:0];
        width_mask = 64'hFFFF_FFFF;
      end
      REG_INV_FOCAL: begin
        inv_shadow = val;
        width_mask = '1;
      end
      REG_ROT_X, REG_ROT_Y, REG_ROT_Z: begin
        rot_shadow[int'(idx) - int'(REG_ROT_X)] = val[53:0];
        width_mask = (64'd1 << 54) - 64'd1;
      end
      default: begin
        shift_shadow[int'(idx) - int'(REG_SHIFT_X)] = val[31:0];
        width_mask = 64'hFFFF_FFFF;
      end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // Register taken at this edge; turn straight into the read-back setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & width_mask) !== (val & width_mask)) begin
      $error("prdata: expected %h, got %h", val & width_mask, prdata & width_mask);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_pose(input logic [63:0] pp, input logic [63:0] inv,
                           input logic [63:0] rx, input logic [63:0] ry,
                           input logic [63:0] rz, input logic [63:0] sx,
                           input logic [63:0] sy, input logic [63:0] sz);
    write_reg(REG_PRINCIPAL, pp);
    write_reg(REG_INV_FOCAL, inv);
    write_reg(REG_ROT_X, rx);
    write_reg(REG_ROT_Y, ry);
    write_reg(REG_ROT_Z, rz);
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    pp_shadow       = PP_RESET;
    inv_shadow      = INV_RESET;
    rot_shadow[0]   = ROT_X_RESET;
    rot_shadow[1]   = ROT_Y_RESET;
    rot_shadow[2]   = ROT_Z_RESET;
    shift_shadow[0] = '0;
    shift_shadow[1] = '0;
    shift_shadow[2] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at reset settings, no idling: corners, depth limits,
    // zero depth dropped, pixels beside the principal point, colour extremes
    queue_pixel(12'd0,    12'd0,    16'd0,      8'hFF, 8'hFF, 8'hFF);
    queue_pixel(12'd0,    12'd0,    16'd1,      8'h00, 8'h00, 8'h00);
    queue_pixel(12'hFFF,  12'hFFF,  16'hFFFF,   8'hFF, 8'hFF, 8'hFF);
    queue_pixel(12'd0,    12'd0,    16'hFFFF,   8'hAA, 8'h55, 8'hAA);
    queue_pixel(12'hFFF,  12'd0,    16'hFFFF,   8'h55, 8'hAA, 8'h55);
    queue_pixel(12'd0,    12'hFFF,  16'hFFFF,   8'h01, 8'h80, 8'hFE);
    queue_pixel(12'hFFF,  12'hFFF,  16'd0,      8'h12, 8'h34, 8'h56);
    queue_pixel(12'd325,  12'd253,  16'd1000,   8'h80, 8'h40, 8'h20);
    queue_pixel(12'd326,  12'd254,  16'd1000,   8'h7F, 8'hBF, 8'hDF);
    queue_pixel(12'd0,    12'd0,    16'd0,      8'h00, 8'h00, 8'h00);
    queue_pixel(12'd640,  12'd480,  16'h8000,   8'hC3, 8'h3C, 8'h99);
    queue_pixel(12'd639,  12'd479,  16'h7FFF,   8'h66, 8'hE7, 8'h18);
    queue_pixel(12'hAAA,  12'h555,  16'hAAAA,   8'hAA, 8'hAA, 8'hAA);
    queue_pixel(12'h555,  12'hAAA,  16'h5555,   8'h55, 8'h55, 8'h55);
    queue_pixel(12'd1,    12'd1,    16'd1,      8'hFF, 8'h00, 8'hFF);
    queue_pixel(12'hFFE,  12'hFFE,  16'hFFFE,   8'h00, 8'hFF, 8'h00);
    queue_pixel(12'd0,    12'hFFF,  16'd0,      8'hFF, 8'hFF, 8'h00);
    queue_pixel(12'd100,  12'd200,  16'd3000,   8'h10, 8'h20, 8'h30);
    queue_pixel(12'd3000, 12'd50,   16'd500,    8'hF0, 8'h0F, 8'hF0);
    queue_pixel(12'd20,   12'd4000, 16'd12345,  8'h0F, 8'hF0, 8'h0F);
    queue_random(100);
    drain_pipeline();

    // Random pose and camera, excess register bits random; idle both sides,
    // and hold the sender halfway until every point has come back
    load_pose({$urandom, $urandom},
              {32'($urandom_range(0, 32'h00FF_FFFF)), 32'($urandom_range(0, 32'h00FF_FFFF))},
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    queue_random(RANDOM_BATCH / 2);
    drain_pipeline();
    queue_random(RANDOM_BATCH / 2);
    drain_pipeline();

    // Upper extremes with every excess bit set: saturate towards the top
    load_pose('1, '1,
              {10'h3FF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF},
              {10'h3FF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF},
              {10'h3FF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF},
              {32'hFFFF_FFFF, 32'h7FFF_FFFF}, {32'hFFFF_FFFF, 32'h7FFF_FFFF},
              {32'hFFFF_FFFF, 32'h7FFF_FFFF});
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    queue_random(RANDOM_BATCH);
    drain_pipeline();

    // Lower extremes: zero camera terms, most negative rotation and shift
    load_pose('0, '0,
              {10'd0, 18'h20000, 18'h20000, 18'h20000},
              {10'd0, 18'h20000, 18'h20000, 18'h20000},
              {10'd0, 18'h20000, 18'h20000, 18'h20000},
              64'h8000_0000, 64'h8000_0000, 64'h8000_0000);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    queue_random(RANDOM_BATCH);
    drain_pipeline();

    // Mixed extremes: principal point at the origin, widest focal scaling,
    // rotation terms of both signs, shifts at both extremes
    load_pose('0, '1,
              {10'd0, 18'h20000, 18'h1FFFF, 18'h20000},
              {10'd0, 18'h1FFFF, 18'h20000, 18'h1FFFF},
              {10'd0, 18'h20000, 18'h20000, 18'h1FFFF},
              64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    queue_random(RANDOM_BATCH);
    drain_pipeline();

    // Fully random register contents
    load_pose({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    queue_random(RANDOM_BATCH);
    drain_pipeline();

    // Identity pose with random translation, no idling
    load_pose({32'd0, PP_RESET}, INV_RESET,
              {10'd0, ROT_X_RESET}, {10'd0, ROT_Y_RESET}, {10'd0, ROT_Z_RESET},
              {32'd0, $urandom}, {32'd0, $urandom}, {32'd0, $urandom});
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    queue_random(RANDOM_BATCH);
    drain_pipeline();

    if (err_cnt == 0 && expected_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dpw_pkg.sv
sv/dpw_cam_axis.sv
sv/dpw_world_axis.sv
sv/depth_pixel_to_world_point_top.sv
tb/tb.sv
